>>> rtl/fm_register_write_monitor_defines.svh
// Assertion macros used by the one RTL file that checks itself
`ifndef FM_REGISTER_WRITE_MONITOR_DEFINES_SVH
`define FM_REGISTER_WRITE_MONITOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define FMRW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define FMRW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fmrw_pkg.sv
package fmrw_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int LEVEL_REGS_PER_BANK_DEF = 16;
    localparam int NUM_CHIPS_DEF = 3;
    localparam int DAC_DECIMATION_DEF = 8;

    localparam int IN_W = 20;
    localparam int OUT_W = 40;

    localparam logic [7:0] DAC_ADDR = 8'h2A;
    localparam logic [7:0] MUTE_LEVEL = 8'h7F;
    localparam logic [7:0] KEY_ADDR = 8'h28;
    localparam logic [7:0] TL_LO = 8'h40;
    localparam logic [7:0] TL_HI = 8'h4F;
    localparam logic [7:0] ALG_LO = 8'hB0;
    localparam logic [7:0] ALG_HI = 8'hB2;
    localparam logic [7:0] PAN_LO = 8'hB4;
    localparam logic [7:0] PAN_HI = 8'hB6;
    localparam logic [6:0] LEVEL_MAX = 7'd127;

    localparam logic [1:0] CFG_OUTPUT_MODE = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_MASK = 2'd1;
    localparam logic [1:0] CFG_PAN_SWAP = 2'd2;

    localparam logic [1:0] MODE_FM_ONLY = 2'd1;
    localparam logic [1:0] MODE_PCM_ONLY = 2'd2;

    localparam logic [1:0] ACT_DROP = 2'd0;
    localparam logic [1:0] ACT_ADDR_DATA = 2'd1;
    localparam logic [1:0] ACT_DATA_ONLY = 2'd2;

    typedef enum logic [2:0] {
        K_DROP, K_DAC, K_TL, K_ALG, K_KEY, K_PAN, K_PLAIN
    } kind_t;

    // Classified request handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [1:0] chip;
        logic       bank;
        logic [7:0] addr;
        logic [7:0] data;
        logic [6:0] tl_val;
        logic [2:0] ch;
        logic       tl_chan;
        logic       track;
    } req_t;

    typedef struct packed {
        logic [1:0] output_mode;
        logic [5:0] channel_mask;
        logic       pan_swap;
    } cfg_t;

    function automatic logic [3:0] carrier_slots(input logic [2:0] alg);
        case (alg)
            3'd4: carrier_slots = 4'h0a;
            3'd5, 3'd6: carrier_slots = 4'h0e;
            3'd7: carrier_slots = 4'h0f;
            default: carrier_slots = 4'h08;
        endcase
    endfunction

    function automatic logic [3:0] slot_offset(input logic [1:0] op);
        case (op)
            2'd1: slot_offset = 4'd8;
            2'd2: slot_offset = 4'd4;
            2'd3: slot_offset = 4'd12;
            default: slot_offset = 4'd0;
        endcase
    endfunction

endpackage

>>> rtl/fmrw_front.sv
module fmrw_front
    import fmrw_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [IN_W-1:0] in_data,
    output logic       q_valid,
    input  logic       q_ready,
    output req_t       q_req
);
    logic       func;
    logic [1:0] chip;
    logic       bank;
    logic [7:0] addr;
    logic [7:0] data;
    req_t       req_next;
    req_t       req_reg;
    logic       valid_reg;

    assign func = in_data[0];
    assign chip = in_data[2:1];
    assign bank = in_data[3];
    assign addr = in_data[11:4];
    assign data = in_data[19:12];

    always_comb begin
        logic [7:0] d;
        logic [1:0] sub;
        logic [2:0] tch;
        logic [5:0] mask;
        d = data;
        sub = addr[1:0];
        tch = {2'b00, bank} * 3'd3 + {1'b0, sub};
        mask = cfg.channel_mask | ((cfg.output_mode == MODE_PCM_ONLY) ? 6'h3F : 6'h00);
        req_next = '0;
        req_next.chip = chip;
        req_next.bank = bank;
        req_next.addr = addr;
        // shadow keeps the level as written, before any muting
        req_next.tl_val = data[6:0];
        req_next.kind = K_PLAIN;
        if (func) begin
            req_next.kind = (cfg.output_mode == MODE_FM_ONLY || 32'(chip) >= NUM_CHIPS)
                ? K_DROP : K_DAC;
            req_next.bank = 1'b0;
            req_next.addr = DAC_ADDR;
        end else if ((cfg.output_mode == MODE_FM_ONLY && addr == DAC_ADDR)
                     || 32'(chip) >= NUM_CHIPS) begin
            req_next.kind = K_DROP;
        end else begin
            if (addr inside {[PAN_LO:PAN_HI]} && cfg.pan_swap)
                d = {d[6], d[7], d[5:0]};
            if (chip == 2'd0) begin
                if (addr inside {[TL_LO:TL_HI]}) begin
                    req_next.kind = K_TL;
                    req_next.tl_chan = (sub != 2'd3);
                    req_next.ch = tch;
                    if (sub != 2'd3 && mask[tch]) d = MUTE_LEVEL;
                end else if (addr inside {[ALG_LO:ALG_HI]}) begin
                    req_next.kind = K_ALG;
                    req_next.ch = {2'b00, bank} * 3'd3 + 3'(addr - ALG_LO);
                end else if (addr == KEY_ADDR) begin
                    if (d[1:0] != 2'd3) begin
                        req_next.kind = K_KEY;
                        req_next.ch = {1'b0, d[1:0]} + (d[2] ? 3'd3 : 3'd0);
                    end
                end else if (addr inside {[PAN_LO:PAN_HI]}) begin
                    req_next.kind = K_PAN;
                    req_next.ch = {2'b00, bank} * 3'd3 + 3'(addr - PAN_LO);
                end
                req_next.track = (addr == DAC_ADDR);
            end
        end
        req_next.data = d;
    end

    assign in_ready = !valid_reg || q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) req_reg <= req_next;
    end

    assign q_valid = valid_reg;
    assign q_req = req_reg;
endmodule

>>> rtl/fmrw_queue.sv
module fmrw_queue
    import fmrw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic w_valid,
    output logic w_ready,
    input  req_t w_req,
    output logic r_valid,
    input  logic r_ready,
    output req_t r_req
);
    req_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;
    logic       pop;

    assign w_ready = (cnt_reg != 2'd2);
    assign r_valid = (cnt_reg != 2'd0);
    assign push = w_valid && w_ready;
    assign pop = r_valid && r_ready;
    assign r_req = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= w_req;
    end
endmodule

>>> rtl/fmrw_back.sv
module fmrw_back
    import fmrw_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LEVEL_REGS_PER_BANK = LEVEL_REGS_PER_BANK_DEF,
    parameter int NUM_CHIPS = NUM_CHIPS_DEF,
    parameter int DAC_DECIMATION = DAC_DECIMATION_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  req_t q_req,
    output logic m_valid,
    input  logic m_ready,
    output logic [OUT_W-1:0] m_data
);
    localparam int NSH = 2 * LEVEL_REGS_PER_BANK;
    localparam int SW = $clog2(NSH);
    localparam int CW = $clog2(DAC_DECIMATION + 1);

    logic [6:0] shadow_reg [NSH];
    logic [NSH-1:0] shadow_valid_reg;
    logic [2:0] alg_reg [NUM_CHANNELS];
    logic [3:0] keys_reg [NUM_CHANNELS];
    logic [7:0] latch_reg [NUM_CHIPS];
    logic [NUM_CHIPS-1:0] latch_valid_reg;
    logic [3:0] peak_reg;
    logic [CW-1:0] count_reg;
    logic [OUT_W-1:0] out_reg;
    logic out_valid_reg;
    logic fire;

    assign q_ready = !out_valid_reg || m_ready;
    assign fire = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        logic [1:0] act;
        logic [7:0] d;
        logic lv, pv, kv, kon;
        logic [2:0] lt;
        logic [3:0] lvl;
        logic [1:0] pc;
        logic [2:0] ch;
        logic cb;
        logic [3:0] keys, car;
        logic [6:0] best, tl;
        logic found, dac_rep, meter;
        logic [SW-1:0] idx;
        logic [7:0] mag;
        logic [3:0] dl, pk;
        logic [CW-1:0] cnt;
        act = ACT_ADDR_DATA;
        d = q_req.data;
        lv = 1'b0; pv = 1'b0; kv = 1'b0; kon = 1'b0; pc = 2'd0;
        lt = 3'd0; lvl = 4'd0; meter = 1'b0; dac_rep = 1'b0;
        ch = q_req.ch;
        // the channel number, not the write port, picks the shadow bank
        cb = (ch > 3'd2);
        keys = keys_reg[ch];
        car = carrier_slots(alg_reg[ch]);
        if (q_req.kind == K_ALG) car = carrier_slots(q_req.data[2:0]);
        if (q_req.kind == K_KEY) keys = q_req.data[7:4];
        best = LEVEL_MAX;
        found = 1'b0;
        mag = d[7] ? {1'b0, d[6:0]} : (8'd128 - d);
        dl = (mag[7] || mag[6:3] > 4'd15) ? 4'd15 : mag[6:3];
        pk = (dl > peak_reg) ? dl : peak_reg;
        cnt = count_reg + 1'b1;
        if (!aresetn) begin
            shadow_valid_reg <= '0;
            latch_valid_reg <= '0;
            peak_reg <= 4'd0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                alg_reg[i] <= 3'd0;
                keys_reg[i] <= 4'd0;
            end
            for (int i = 0; i < NUM_CHIPS; i++) latch_reg[i] <= 8'd0;
        end else begin
            if (m_ready) out_valid_reg <= 1'b0;
            if (fire) begin
                out_valid_reg <= 1'b1;
                for (int op = 0; op < 4; op++) begin
                    idx = SW'({4'd0, cb} * LEVEL_REGS_PER_BANK
                              + slot_offset(2'(op)) + ch - (cb ? 3'd3 : 3'd0));
                    tl = shadow_reg[idx];
                    if (q_req.kind == K_TL && idx == SW'({q_req.bank, q_req.addr[3:0]}))
                        tl = q_req.tl_val;
                    if (car[op] && keys[op] && (shadow_valid_reg[idx]
                        || (q_req.kind == K_TL && idx == SW'({q_req.bank, q_req.addr[3:0]}))))
                    begin
                        if (!found || tl < best) best = tl;
                        found = 1'b1;
                    end
                end
                if (q_req.kind == K_TL) begin
                    shadow_reg[SW'({q_req.bank, q_req.addr[3:0]})] <= q_req.tl_val;
                    shadow_valid_reg[SW'({q_req.bank, q_req.addr[3:0]})] <= 1'b1;
                end
                case (q_req.kind)
                    K_DROP: act = ACT_DROP;
                    K_DAC: begin
                        if (latch_valid_reg[q_req.chip] && latch_reg[q_req.chip] == DAC_ADDR)
                            act = ACT_DATA_ONLY;
                        latch_reg[q_req.chip] <= DAC_ADDR;
                        latch_valid_reg[q_req.chip] <= 1'b1;
                        dac_rep = (q_req.chip == 2'd0);
                    end
                    K_TL: meter = q_req.tl_chan;
                    K_ALG: begin
                        alg_reg[ch] <= q_req.data[2:0];
                        meter = 1'b1;
                    end
                    K_KEY: begin
                        keys_reg[ch] <= q_req.data[7:4];
                        kv = 1'b1;
                        kon = (q_req.data[7:4] != 4'd0);
                        meter = 1'b1;
                    end
                    K_PAN: begin
                        pv = 1'b1;
                        pc = {q_req.data[6], q_req.data[7]};
                    end
                    default: act = ACT_ADDR_DATA;
                endcase
                if (q_req.kind != K_DROP && q_req.kind != K_DAC) begin
                    latch_reg[q_req.chip] <= q_req.addr;
                    latch_valid_reg[q_req.chip] <= 1'b1;
                    dac_rep = q_req.track;
                end
                if (meter) begin
                    lv = 1'b1;
                    lt = ch;
                    lvl = (found && keys != 4'd0) ? 4'((LEVEL_MAX - best) >> 3) : 4'd0;
                end
                if (dac_rep) begin
                    if (32'(cnt) >= DAC_DECIMATION) begin
                        count_reg <= '0;
                        peak_reg <= 4'd0;
                        lv = 1'b1;
                        lt = 3'd6;
                        lvl = pk;
                    end else begin
                        count_reg <= cnt;
                        peak_reg <= pk;
                    end
                end
                if (act == ACT_DROP) out_reg <= '0;
                else out_reg <= {5'd0, kon, kv, pc, 3'(pv ? ch : 3'd0), pv, lvl, lt, lv,
                                 d, q_req.addr, q_req.bank, act};
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
endmodule

>>> rtl/fm_register_write_monitor.sv
// FM register write monitor.
// Slave stream (s_*) takes one register write or DAC sample per request;
// s_tdata packs func, chip_index, bank, reg_addr, value from bit 0 up.
// Master stream (m_*) returns exactly one result per request with
// bus_action, out_bank, out_addr, out_data, level and pan and key reports.
// Configuration goes through cfg_we / cfg_index / cfg_data; the user must
// write it only while idle; the block does not enforce this. A request
// passes front register, two-entry queue and back output register before
// m_tvalid rises. Throughput: one request per cycle with m_tready high.
// A stalled master holds its result; up to four requests wait inside
// (output register, two queue entries, front register), after which
// s_tready drops until the master side drains.
// Reset (aresetn low, synchronous) clears configuration, shadows, key
// slots, address latches and the DAC peak meter, and empties the pipeline.
module fm_register_write_monitor
    import fmrw_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LEVEL_REGS_PER_BANK = LEVEL_REGS_PER_BANK_DEF,
    parameter int NUM_CHIPS = NUM_CHIPS_DEF,
    parameter int DAC_DECIMATION = DAC_DECIMATION_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // func, chip_index[2], bank, reg_addr[8], value[8], zero fill
    input  logic [23:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // bus_action[2], out_bank, out_addr[8], out_data[8], level_valid,
    // level_track[3], level_value[4], pan_valid, pan_channel[3], pan_code[2],
    // key_valid, key_on, zero fill
    output logic [39:0] m_tdata,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);
`include "fm_register_write_monitor_defines.svh"

    cfg_t cfg_reg;
    req_t f_req, b_req;
    logic f_valid, f_ready, b_valid, b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OUTPUT_MODE: cfg_reg.output_mode <= cfg_data[1:0];
                CFG_CHANNEL_MASK: cfg_reg.channel_mask <= cfg_data;
                CFG_PAN_SWAP: cfg_reg.pan_swap <= cfg_data[0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    fmrw_front #(.NUM_CHIPS(NUM_CHIPS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[IN_W-1:0]),
        .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
    );

    fmrw_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .w_valid(f_valid), .w_ready(f_ready), .w_req(f_req),
        .r_valid(b_valid), .r_ready(b_ready), .r_req(b_req)
    );

    fmrw_back #(
        .NUM_CHANNELS(NUM_CHANNELS), .LEVEL_REGS_PER_BANK(LEVEL_REGS_PER_BANK),
        .NUM_CHIPS(NUM_CHIPS), .DAC_DECIMATION(DAC_DECIMATION)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
    );

    `FMRW_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `FMRW_ASSERT_IMP(a_drop, aclk, aresetn, m_tvalid && m_tdata[1:0] == ACT_DROP, m_tdata == '0, "dropped result not zero")
    `FMRW_ASSERT_IMP(a_act, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "bad bus action")
endmodule
